// ===== rtl/core/rplu_pkg.sv =====
// Shared types and constants for the raw pixel line unpacker.
// Used by every module under rtl/core; depends on nothing else.
package rplu_pkg;

  // Geometry limits and field widths.
  localparam int WIDTH_W      = 14;
  localparam int STRIDE_W     = 15;
  localparam int LINE_W       = 13;
  localparam int PIX_CNT_W    = 14;
  localparam int PIXEL_W      = 16;
  localparam int BYTE_W       = 8;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_INDEX_W  = 2;
  localparam int MAX_RESULTS  = 4;
  localparam int COUNT_W      = 3;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH  = 14'd8192;
  localparam logic [WIDTH_W-1:0] MAX_HEIGHT = 14'd8192;

  // Masks for the low-bits byte of RAW10 and RAW12 groups.
  localparam logic [BYTE_W-1:0] LOW2_MASK = 8'h03;
  localparam logic [BYTE_W-1:0] LOW4_MASK = 8'h0F;

  typedef enum logic [1:0] {
    MODE_RAW8  = 2'd0,
    MODE_RAW10 = 2'd1,
    MODE_RAW12 = 2'd2,
    MODE_RAW16 = 2'd3
  } pixel_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_MODE  = 2'd0,
    REG_LINE_PIXELS = 2'd1,
    REG_FRAME_LINES = 2'd2,
    REG_LINE_STRIDE = 2'd3
  } reg_index_t;

  typedef struct packed {
    pixel_mode_t          pixel_mode;
    logic [WIDTH_W-1:0]   line_pixels;
    logic [WIDTH_W-1:0]   frame_lines;
    logic [STRIDE_W-1:0]  line_stride;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_line;
    logic               end_of_frame;
    logic               stride_error;
  } result_t;

  // All results caused by one input byte; count is 0 to MAX_RESULTS.
  typedef struct packed {
    logic [COUNT_W-1:0]          count;
    result_t [MAX_RESULTS-1:0]   res;
  } batch_t;

endpackage

// ===== rtl/core/rplu_frame_ctrl.sv =====
// Frame position counters, group byte store and per-byte unpack decode.
// Depends on rplu_pkg.
module rplu_frame_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  rplu_pkg::cfg_t                      cfg,
  input  logic [rplu_pkg::BYTE_W-1:0]         byte_value,
  input  logic                                take,
  output rplu_pkg::batch_t                    batch
);

  logic [rplu_pkg::STRIDE_W-1:0]  byte_position;
  logic [rplu_pkg::LINE_W-1:0]    line_count;
  logic [rplu_pkg::PIX_CNT_W-1:0] pixels_done;
  logic                           frame_dropping;
  logic [2:0]                     grp_mod5;
  logic [1:0]                     grp_mod3;
  logic [rplu_pkg::BYTE_W-1:0]    group_bytes [rplu_pkg::MAX_RESULTS];

  logic [rplu_pkg::WIDTH_W-1:0]   w;
  logic [rplu_pkg::WIDTH_W-1:0]   h;
  logic [rplu_pkg::STRIDE_W-1:0]  stride;
  logic [rplu_pkg::STRIDE_W-1:0]  need;
  logic [rplu_pkg::STRIDE_W-1:0]  q10;
  logic [rplu_pkg::STRIDE_W-1:0]  q12;
  logic [rplu_pkg::STRIDE_W-1:0]  full10;
  logic [rplu_pkg::STRIDE_W-1:0]  full12;
  logic [rplu_pkg::STRIDE_W-1:0]  full_bytes;
  logic [rplu_pkg::STRIDE_W-1:0]  tail10;
  logic                           raw10;
  logic                           in_full;
  logic [2:0]                     pos;
  logic [2:0]                     cnt;
  logic                           start_err;
  logic                           active;
  logic                           store_en;
  logic [1:0]                     store_idx;
  logic [rplu_pkg::COUNT_W-1:0]   n_emit;
  logic [rplu_pkg::PIXEL_W-1:0]   pix [rplu_pkg::MAX_RESULTS];
  logic [rplu_pkg::PIX_CNT_W-1:0] pd_i;
  logic                           eol_i;
  logic                           last_line;
  logic                           line_end;
  logic [1:0]                     lo2;
  logic [3:0]                     lo4;

  // Effective geometry.
  always_comb begin
    if (cfg.line_pixels == '0) begin
      w = rplu_pkg::WIDTH_W'(1);
    end else if (cfg.line_pixels > rplu_pkg::MAX_WIDTH) begin
      w = rplu_pkg::MAX_WIDTH;
    end else begin
      w = cfg.line_pixels;
    end
    if (cfg.frame_lines == '0) begin
      h = rplu_pkg::WIDTH_W'(1);
    end else if (cfg.frame_lines > rplu_pkg::MAX_HEIGHT) begin
      h = rplu_pkg::MAX_HEIGHT;
    end else begin
      h = cfg.frame_lines;
    end
    stride = (cfg.line_stride == '0) ? rplu_pkg::STRIDE_W'(1) : cfg.line_stride;
  end

  // Packed line length: whole groups by shift and add, then the short tail.
  assign q10    = {3'b000, w[rplu_pkg::WIDTH_W-1:2]};
  assign q12    = {2'b00, w[rplu_pkg::WIDTH_W-1:1]};
  assign full10 = (q10 << 2) + q10;
  assign full12 = (q12 << 1) + q12;
  assign tail10 = (w[1:0] == 2'd0) ? '0 : {13'd0, w[1:0]} + rplu_pkg::STRIDE_W'(1);

  always_comb begin
    unique case (cfg.pixel_mode)
      rplu_pkg::MODE_RAW8:  need = {1'b0, w};
      rplu_pkg::MODE_RAW10: need = full10 + tail10;
      rplu_pkg::MODE_RAW12: need = full12 + (w[0] ? rplu_pkg::STRIDE_W'(2) : '0);
      rplu_pkg::MODE_RAW16: need = {w, 1'b0};
      default:              need = {1'b0, w};
    endcase
  end

  assign raw10      = (cfg.pixel_mode == rplu_pkg::MODE_RAW10);
  assign full_bytes = raw10 ? full10 : full12;
  assign in_full    = byte_position < full_bytes;
  assign pos        = in_full ? (raw10 ? grp_mod5 : {1'b0, grp_mod3})
                              : 3'(byte_position - full_bytes);
  assign cnt        = in_full ? (raw10 ? 3'd4 : 3'd2)
                              : (raw10 ? {1'b0, w[1:0]} : {2'b00, w[0]});

  assign start_err = (byte_position == '0) && (line_count == '0) && !frame_dropping
                     && (stride < need);
  assign active    = !frame_dropping && (byte_position < need);
  assign last_line = ({1'b0, line_count} + rplu_pkg::WIDTH_W'(1)) >= h;
  assign line_end  = ({1'b0, byte_position} + 16'd1) >= {1'b0, stride};

  // Decide what this byte does: store a group byte, emit pixels, or both none.
  always_comb begin
    store_en  = 1'b0;
    store_idx = 2'd0;
    n_emit    = '0;
    for (int i = 0; i < rplu_pkg::MAX_RESULTS; i++) begin
      lo2 = 2'((byte_value >> (2 * i)) & rplu_pkg::LOW2_MASK);
      lo4 = 4'((byte_value >> (4 * i)) & rplu_pkg::LOW4_MASK);
      pix[i] = raw10 ? {6'd0, group_bytes[i], lo2} : {4'd0, group_bytes[i], lo4};
    end
    if (!start_err && active) begin
      unique case (cfg.pixel_mode)
        rplu_pkg::MODE_RAW8: begin
          n_emit = rplu_pkg::COUNT_W'(1);
          pix[0] = {8'd0, byte_value};
        end
        rplu_pkg::MODE_RAW16: begin
          if (!byte_position[0]) begin
            store_en = 1'b1;
          end else begin
            n_emit = rplu_pkg::COUNT_W'(1);
            pix[0] = {byte_value, group_bytes[0]};
          end
        end
        default: begin
          if (pos < cnt) begin
            store_en  = 1'b1;
            store_idx = pos[1:0];
          end else begin
            n_emit = cnt;
          end
        end
      endcase
    end
  end

  // Line and frame flags for each emitted pixel.
  always_comb begin
    batch = '0;
    for (int i = 0; i < rplu_pkg::MAX_RESULTS; i++) begin
      pd_i  = pixels_done + rplu_pkg::PIX_CNT_W'(i);
      eol_i = ({1'b0, pd_i} + 15'd1) == {1'b0, w};
      batch.res[i].pixel        = pix[i];
      batch.res[i].end_of_line  = eol_i;
      batch.res[i].end_of_frame = eol_i && last_line;
      batch.res[i].stride_error = 1'b0;
    end
    batch.count = n_emit;
    if (start_err) begin
      batch.count  = rplu_pkg::COUNT_W'(1);
      batch.res[0] = '{pixel: '0, end_of_line: 1'b0, end_of_frame: 1'b0,
                       stride_error: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      line_count     <= '0;
      pixels_done    <= '0;
      frame_dropping <= 1'b0;
      grp_mod5       <= '0;
      grp_mod3       <= '0;
    end else if (take) begin
      if (line_end) begin
        byte_position <= '0;
        pixels_done   <= '0;
        grp_mod5      <= '0;
        grp_mod3      <= '0;
        if (last_line) begin
          line_count     <= '0;
          frame_dropping <= 1'b0;
        end else begin
          line_count     <= line_count + rplu_pkg::LINE_W'(1);
          frame_dropping <= frame_dropping | start_err;
        end
      end else begin
        byte_position  <= byte_position + rplu_pkg::STRIDE_W'(1);
        pixels_done    <= pixels_done + rplu_pkg::PIX_CNT_W'(n_emit);
        grp_mod5       <= (grp_mod5 == 3'd4) ? 3'd0 : grp_mod5 + 3'd1;
        grp_mod3       <= (grp_mod3 == 2'd2) ? 2'd0 : grp_mod3 + 2'd1;
        frame_dropping <= frame_dropping | start_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && store_en) begin
      group_bytes[store_idx] <= byte_value;
    end
  end

endmodule

// ===== rtl/core/rplu_result_buf.sv =====
// Result register: holds one byte's results, sends one per cycle on out_ready.
// Depends on rplu_pkg.
module rplu_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  rplu_pkg::batch_t  batch,
  input  logic              load,
  output logic              load_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rplu_pkg::result_t out_result,
  output logic              out_last
);

  rplu_pkg::batch_t held;
  logic [1:0]       idx;
  logic             busy;
  logic             final_res;

  assign final_res  = ({1'b0, idx} + rplu_pkg::COUNT_W'(1)) == held.count;
  assign load_ready = !busy || (out_ready && final_res);
  assign out_valid  = busy;
  assign out_result = held.res[idx];
  assign out_last   = final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (final_res) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= batch;
    end
  end

endmodule

// ===== rtl/core/raw_pixel_line_unpacker_core.sv =====
// Top level of the raw pixel line unpacker: configuration registers, input
// register, and the decode and result stages. Depends on rplu_pkg,
// rplu_frame_ctrl and rplu_result_buf.
//
// The block takes a packed raw sensor frame one byte per request and sends
// out right-aligned pixels in RAW8, RAW10, RAW12 or RAW16 (little endian)
// packing. A frame is frame_lines lines of line_stride bytes; the first
// bytes of each line carry line_pixels pixels and the rest is padding that
// gives nothing. Each packing group gives its pixels on the byte that
// closes it, and a short group at the end of a line is closed by its
// low-bits byte right after its high bytes. If line_stride is too small for
// the width in the current mode, the first byte of the frame gives one
// result with stride_error set and the rest of that frame is dropped.
// Timing: a byte is registered at the input and decoded in the next cycle
// against the frame counters; when it moves on, its results are loaded into
// the result register, which offers them to the sink. The result register
// sends one result per cycle while the sink is ready. A byte that gives no
// result moves on at once; a byte that gives results waits in the input
// register until the result register is empty or sending its final result.
// While the sink is ready, full groups never wait, since a group of n pixels
// spans at least n bytes, but a short RAW10 tail right after a full group
// does: a one-pixel or two-pixel tail holds its low-bits byte in the input
// register until the group's final result is being sent. Otherwise a byte
// is accepted every cycle while the sink is ready.
// Configuration writes take effect at once and should be made only while
// no request is in flight; counters are not cleared by a write.
module raw_pixel_line_unpacker_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [rplu_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rplu_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input byte stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [7:0] byte_value
  // Pixel stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [15:0]                           m_axis_tdata,  // [15:0] pixel
  output logic [2:0]                            m_axis_tuser,  // [0] end_of_line,
                                                               // [1] end_of_frame,
                                                               // [2] stride_error
  output logic                                  m_axis_tlast   // last result of a byte
);

  rplu_pkg::cfg_t                  cfg;
  logic                            in_valid;
  logic [rplu_pkg::BYTE_W-1:0]     in_byte;
  logic                            advance;
  logic                            load_ready;
  rplu_pkg::batch_t                batch;
  rplu_pkg::result_t               out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode  <= rplu_pkg::MODE_RAW8;
      cfg.line_pixels <= rplu_pkg::WIDTH_W'(1);
      cfg.frame_lines <= rplu_pkg::WIDTH_W'(1);
      cfg.line_stride <= rplu_pkg::STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (rplu_pkg::reg_index_t'(cfg_index))
        rplu_pkg::REG_PIXEL_MODE:  cfg.pixel_mode  <= rplu_pkg::pixel_mode_t'(cfg_data[1:0]);
        rplu_pkg::REG_LINE_PIXELS: cfg.line_pixels <= cfg_data[rplu_pkg::WIDTH_W-1:0];
        rplu_pkg::REG_FRAME_LINES: cfg.frame_lines <= cfg_data[rplu_pkg::WIDTH_W-1:0];
        rplu_pkg::REG_LINE_STRIDE: cfg.line_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // The registered byte moves on when it gives no result or when the result
  // register is free or sending its final result in this cycle.
  assign advance       = in_valid && ((batch.count == '0) || load_ready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  rplu_frame_ctrl u_frame_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_value (in_byte),
    .take       (advance),
    .batch      (batch)
  );

  rplu_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .load       (advance && (batch.count != '0)),
    .load_ready (load_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = out_result.pixel;
  assign m_axis_tuser = {out_result.stride_error, out_result.end_of_frame,
                         out_result.end_of_line};

endmodule
